/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the deauth flood source counter.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge outside reset.
`define DFSC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dfsc assertion failed");

// Checked on every rising edge, reset included.
`define DFSC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dfsc assertion failed");

`else

`define DFSC_ASSERT(lbl, clk, rst, prop)
`define DFSC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/dfsc_pkg.sv */
// Types, codes and helpers for the deauth flood source counter.
// Used by dfsc_front, dfsc_back and the top level; depends on nothing.
`default_nettype none

package dfsc_pkg;

  localparam int MAC_W   = 48;
  localparam int CNT_W   = 32;
  localparam int THR_W   = 16;
  localparam int PCT_W   = 7;
  localparam int PROD_W  = CNT_W + PCT_W;
  localparam int Q_DEPTH = 2;

  // frame_class codes
  localparam logic [1:0] CLASS_OTHER  = 2'd0;
  localparam logic [1:0] CLASS_DEAUTH = 2'd1;
  localparam logic [1:0] CLASS_DATA   = 2'd2;

  // mode codes
  localparam logic MODE_FRAME  = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_FLOOD_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_CRITICAL_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_RATIO_PERCENT      = 2'd2;

  localparam logic [THR_W-1:0] FLOOD_THRESHOLD_RST    = 16'd10;
  localparam logic [THR_W-1:0] CRITICAL_THRESHOLD_RST = 16'd50;
  localparam logic [PCT_W-1:0] RATIO_PERCENT_RST      = 7'd5;
  localparam logic [PROD_W-1:0] PERCENT_SCALE         = 39'd100;

  typedef enum logic [1:0] {
    OP_OTHER,
    OP_DEAUTH,
    OP_DATA,
    OP_REPORT
  } op_t;

  typedef enum logic [1:0] {
    KIND_FLOOD,
    KIND_SUMMARY,
    KIND_RATIO
  } kind_t;

  typedef enum logic [1:0] {
    LVL_INFO,
    LVL_WARNING,
    LVL_CRITICAL
  } severity_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_PROD,
    S_SUM,
    S_RATIO
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [MAC_W-1:0] mac;
  } qentry_t;

  typedef struct packed {
    logic [THR_W-1:0] flood_threshold;
    logic [THR_W-1:0] critical_threshold;
    logic [PCT_W-1:0] ratio_percent;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    severity_t        severity;
    logic [MAC_W-1:0] flood_mac;
    logic [CNT_W-1:0] flood_count;
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] deauth_count;
    logic [CNT_W-1:0] data_count;
    logic             last;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* rtl/dfsc_front.sv */
// Front end: accepts input items, classifies them into operations and
// buffers them in a two-entry queue. Depends on dfsc_pkg.
`default_nettype none

module dfsc_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      mode,
  input  wire logic [1:0]                frame_class,
  input  wire logic [dfsc_pkg::MAC_W-1:0] src_mac,
  output logic                           q_valid,
  output dfsc_pkg::qentry_t              q_entry,
  input  wire logic                      q_pop
);

  dfsc_pkg::qentry_t entries [dfsc_pkg::Q_DEPTH];
  dfsc_pkg::qentry_t classified;
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              push;

  always_comb begin
    classified.mac = src_mac;
    if (mode == dfsc_pkg::MODE_REPORT) begin
      classified.op = dfsc_pkg::OP_REPORT;
    end else begin
      case (frame_class)
        dfsc_pkg::CLASS_DEAUTH: classified.op = dfsc_pkg::OP_DEAUTH;
        dfsc_pkg::CLASS_DATA:   classified.op = dfsc_pkg::OP_DATA;
        default:                classified.op = dfsc_pkg::OP_OTHER;
      endcase
    end
  end

  assign in_stall = (fill == 2'(dfsc_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_entry  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/dfsc_back.sv */
// Back end: source table, session counters, report sequencer and the
// output register. Depends on dfsc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dfsc_back #(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire dfsc_pkg::qentry_t q_entry,
  output logic                   q_pop,
  input  wire dfsc_pkg::cfg_t    cfg,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dfsc_pkg::result_t      result
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int CW = dfsc_pkg::CNT_W;
  localparam int PW = dfsc_pkg::PROD_W;

  dfsc_pkg::state_t          state;
  dfsc_pkg::state_t          state_next;

  logic [dfsc_pkg::MAC_W-1:0] mac_tab   [TABLE_ENTRIES];
  logic [CW-1:0]              count_tab [TABLE_ENTRIES];
  logic [UW-1:0]              used;
  logic [CW-1:0]              frames_total;
  logic [CW-1:0]              frames_deauth;
  logic [CW-1:0]              frames_data;

  logic [dfsc_pkg::MAC_W-1:0] cur_mac;
  logic [TABLE_ENTRIES-1:0]   match;
  logic [TABLE_ENTRIES-1:0]   match_now;
  logic [IW-1:0]              hit;
  logic [IW-1:0]              hit_now;
  logic [UW-1:0]              scan_idx;
  logic [PW-1:0]              prod_deauth;
  logic [PW-1:0]              prod_total;

  logic slot_free;
  logic scan_done;
  logic scan_hit;
  logic warn;
  logic table_write;
  logic table_insert;
  logic out_load;
  logic report_start;
  logic [CW-1:0] scan_count;

  // parallel compare of the queue head against every live entry
  always_comb begin
    hit_now = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_now[i] = (mac_tab[i] == q_entry.mac) && (UW'(i) < used);
      hit_now      = hit_now | (match_now[i] ? IW'(i) : '0);
    end
  end

  assign slot_free  = !out_valid || !out_stall;
  assign scan_done  = (scan_idx >= used);
  assign scan_count = count_tab[scan_idx[IW-1:0]];
  assign scan_hit   = scan_count > {{(CW-dfsc_pkg::THR_W){1'b0}}, cfg.flood_threshold};
  assign warn       = prod_deauth > prod_total;

  assign table_write  = (state == dfsc_pkg::S_UPDATE);
  assign table_insert = table_write && !(|match) && (used < UW'(TABLE_ENTRIES));

  assign report_start = (state == dfsc_pkg::S_IDLE) && q_valid &&
                        (q_entry.op == dfsc_pkg::OP_REPORT);

  // a new result is loaded into the output register this cycle
  assign out_load = ((state == dfsc_pkg::S_SCAN) && !scan_done && slot_free && scan_hit) ||
                    (((state == dfsc_pkg::S_SUM) || (state == dfsc_pkg::S_RATIO)) &&
                     slot_free);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      dfsc_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_entry.op == dfsc_pkg::OP_REPORT) begin
            state_next = dfsc_pkg::S_SCAN;
          end else if (q_entry.op == dfsc_pkg::OP_DEAUTH) begin
            state_next = dfsc_pkg::S_UPDATE;
          end
        end
      end
      dfsc_pkg::S_UPDATE: state_next = dfsc_pkg::S_IDLE;
      dfsc_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = dfsc_pkg::S_PROD;
        end
      end
      dfsc_pkg::S_PROD: state_next = dfsc_pkg::S_SUM;
      dfsc_pkg::S_SUM: begin
        if (slot_free) begin
          state_next = warn ? dfsc_pkg::S_RATIO : dfsc_pkg::S_IDLE;
        end
      end
      dfsc_pkg::S_RATIO: begin
        if (slot_free) begin
          state_next = dfsc_pkg::S_IDLE;
        end
      end
      default: state_next = dfsc_pkg::S_IDLE;
    endcase
  end

  // table storage: no reset, only entries below used are ever read
  always_ff @(posedge clk) begin
    if (table_write) begin
      if (|match) begin
        count_tab[hit] <= dfsc_pkg::sat_inc(count_tab[hit]);
      end else if (table_insert) begin
        mac_tab[used[IW-1:0]]   <= cur_mac;
        count_tab[used[IW-1:0]] <= CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dfsc_pkg::S_IDLE;
      used          <= '0;
      frames_total  <= '0;
      frames_deauth <= '0;
      frames_data   <= '0;
      scan_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        dfsc_pkg::S_IDLE: begin
          if (q_valid) begin
            case (q_entry.op)
              dfsc_pkg::OP_REPORT: scan_idx <= '0;
              dfsc_pkg::OP_DEAUTH: begin
                frames_total  <= dfsc_pkg::sat_inc(frames_total);
                frames_deauth <= dfsc_pkg::sat_inc(frames_deauth);
                cur_mac       <= q_entry.mac;
                match         <= match_now;
                hit           <= hit_now;
              end
              dfsc_pkg::OP_DATA: begin
                frames_total <= dfsc_pkg::sat_inc(frames_total);
                frames_data  <= dfsc_pkg::sat_inc(frames_data);
              end
              default: frames_total <= dfsc_pkg::sat_inc(frames_total);
            endcase
          end
        end
        dfsc_pkg::S_UPDATE: begin
          if (table_insert) begin
            used <= used + UW'(1);
          end
        end
        dfsc_pkg::S_SCAN: begin
          if (!scan_done && slot_free) begin
            scan_idx <= scan_idx + UW'(1);
            if (scan_hit) begin
              result.kind        <= dfsc_pkg::KIND_FLOOD;
              result.severity    <= (scan_count >
                                     {{(CW-dfsc_pkg::THR_W){1'b0}}, cfg.critical_threshold})
                                    ? dfsc_pkg::LVL_CRITICAL : dfsc_pkg::LVL_WARNING;
              result.flood_mac   <= mac_tab[scan_idx[IW-1:0]];
              result.flood_count <= scan_count;
              result.total_count  <= frames_total;
              result.deauth_count <= frames_deauth;
              result.data_count   <= frames_data;
              result.last         <= 1'b0;
            end
          end
        end
        dfsc_pkg::S_PROD: begin
          // exact ratio test: deauth * 100 > percent * total
          prod_deauth <= {{(PW-CW){1'b0}}, frames_deauth} * dfsc_pkg::PERCENT_SCALE;
          prod_total  <= {{(PW-dfsc_pkg::PCT_W){1'b0}}, cfg.ratio_percent}
                         * {{(PW-CW){1'b0}}, frames_total};
        end
        dfsc_pkg::S_SUM: begin
          if (slot_free) begin
            result.kind         <= dfsc_pkg::KIND_SUMMARY;
            result.severity     <= dfsc_pkg::LVL_INFO;
            result.flood_mac    <= '0;
            result.flood_count  <= '0;
            result.total_count  <= frames_total;
            result.deauth_count <= frames_deauth;
            result.data_count   <= frames_data;
            result.last         <= !warn;
            if (!warn) begin
              used          <= '0;
              frames_total  <= '0;
              frames_deauth <= '0;
              frames_data   <= '0;
            end
          end
        end
        dfsc_pkg::S_RATIO: begin
          if (slot_free) begin
            result.kind         <= dfsc_pkg::KIND_RATIO;
            result.severity     <= dfsc_pkg::LVL_WARNING;
            result.flood_mac    <= '0;
            result.flood_count  <= '0;
            result.total_count  <= frames_total;
            result.deauth_count <= frames_deauth;
            result.data_count   <= frames_data;
            result.last         <= 1'b1;
            used          <= '0;
            frames_total  <= '0;
            frames_deauth <= '0;
            frames_data   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `DFSC_ASSERT(a_used_bound, clk, rst, used <= UW'(TABLE_ENTRIES))
  `DFSC_ASSERT(a_match_unique, clk, rst, (state == dfsc_pkg::S_UPDATE) |-> $onehot0(match))
  `DFSC_ASSERT(a_insert_grows, clk, rst, table_insert |=> used == $past(used) + UW'(1))
  `DFSC_ASSERT(a_report_starts, clk, rst, report_start |=> (state == dfsc_pkg::S_SCAN))
  `DFSC_ASSERT(a_session_clears, clk, rst, (state == dfsc_pkg::S_RATIO && slot_free) |=> (used == '0 && frames_total == '0 && out_valid))

endmodule

`default_nettype wire

/* rtl/deauth_flood_source_counter.sv */
// Top level of the deauth flood source counter: configuration registers,
// front queue and back end. Depends on dfsc_pkg, dfsc_front, dfsc_back.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | mode, frame_class, src_mac
//   out     | output    | out_valid/out_stall | kind .. last, one result each
//   cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// A frame is handled in the idle state, a deauth frame also in the update state
// (table compare, then count update or insert); a two-entry queue decouples
// input from the back end. A report steps through pop, one scan step per
// stored source, scan end, product and summary, then a ratio warning if one
// is due; out_stall holding results stalls the scan and the output states.
// Reset is synchronous; the source table needs no sweep.
`default_nettype none

module deauth_flood_source_counter #(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       mode,
  input  wire logic [1:0]                 frame_class,
  input  wire logic [dfsc_pkg::MAC_W-1:0] src_mac,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      kind,
  output logic [1:0]                      severity,
  output logic [dfsc_pkg::MAC_W-1:0]      flood_mac,
  output logic [dfsc_pkg::CNT_W-1:0]      flood_count,
  output logic [dfsc_pkg::CNT_W-1:0]      total_count,
  output logic [dfsc_pkg::CNT_W-1:0]      deauth_count,
  output logic [dfsc_pkg::CNT_W-1:0]      data_count,
  output logic                            last,
  input  wire logic                       cfg_write,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [dfsc_pkg::THR_W-1:0] cfg_data
);

  dfsc_pkg::cfg_t    cfg;
  dfsc_pkg::qentry_t q_entry;
  dfsc_pkg::result_t result;
  logic              q_valid;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flood_threshold    <= dfsc_pkg::FLOOD_THRESHOLD_RST;
      cfg.critical_threshold <= dfsc_pkg::CRITICAL_THRESHOLD_RST;
      cfg.ratio_percent      <= dfsc_pkg::RATIO_PERCENT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dfsc_pkg::REG_FLOOD_THRESHOLD:    cfg.flood_threshold    <= cfg_data;
        dfsc_pkg::REG_CRITICAL_THRESHOLD: cfg.critical_threshold <= cfg_data;
        dfsc_pkg::REG_RATIO_PERCENT:
          cfg.ratio_percent <= cfg_data[dfsc_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  dfsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .frame_class (frame_class),
    .src_mac     (src_mac),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop)
  );

  dfsc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign kind         = result.kind;
  assign severity     = result.severity;
  assign flood_mac    = result.flood_mac;
  assign flood_count  = result.flood_count;
  assign total_count  = result.total_count;
  assign deauth_count = result.deauth_count;
  assign data_count   = result.data_count;
  assign last         = result.last;

endmodule

`default_nettype wire

/* sim/flood_report_checker.sv */
// Checker for the deauth flood source counter: watches the frame, result and
// register channels, predicts each session report and compares it field by field.
// Depends on dfsc_pkg only.
module flood_report_checker #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       mode,
  input  logic [1:0]                 frame_class,
  input  logic [dfsc_pkg::MAC_W-1:0] src_mac,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 kind,
  input  logic [1:0]                 severity,
  input  logic [dfsc_pkg::MAC_W-1:0] flood_mac,
  input  logic [dfsc_pkg::CNT_W-1:0] flood_count,
  input  logic [dfsc_pkg::CNT_W-1:0] total_count,
  input  logic [dfsc_pkg::CNT_W-1:0] deauth_count,
  input  logic [dfsc_pkg::CNT_W-1:0] data_count,
  input  logic                       last,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [dfsc_pkg::THR_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         pending,
  output int                         results_seen,
  output int                         floods_seen,
  output int                         ratio_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfsc_pkg::*;

  logic [MAC_W-1:0] src_table [DEPTH];
  logic [CNT_W-1:0] hit_table [DEPTH];
  int               sources;
  logic [CNT_W-1:0] frames_all;
  logic [CNT_W-1:0] frames_deauth_n;
  logic [CNT_W-1:0] frames_data_n;
  logic [THR_W-1:0] flood_thr;
  logic [THR_W-1:0] crit_thr;
  logic [PCT_W-1:0] ratio_pct;
  result_t          report_queue [$];

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic clear_session();
    sources = 0;
    frames_all = '0;
    frames_deauth_n = '0;
    frames_data_n = '0;
  endtask

  task automatic tally_frame(input logic [1:0] cls, input logic [MAC_W-1:0] mac);
    int i;
    bit hit;
    hit = 1'b0;
    frames_all = count_up(frames_all);
    if (cls == CLASS_DEAUTH) begin
      frames_deauth_n = count_up(frames_deauth_n);
      for (i = 0; i < sources && !hit; i++) begin
        if (src_table[i] == mac) begin
          hit_table[i] = count_up(hit_table[i]);
          hit = 1'b1;
        end
      end
      // full table: the source is dropped, the frame still counts
      if (!hit && sources < DEPTH) begin
        src_table[sources] = mac;
        hit_table[sources] = 1;
        sources++;
      end
    end else if (cls == CLASS_DATA) begin
      frames_data_n = count_up(frames_data_n);
    end
  endtask

  task automatic predict_report();
    result_t r;
    int i;
    logic [63:0] share;
    logic [63:0] bound;
    bit warn;
    r.total_count = frames_all;
    r.deauth_count = frames_deauth_n;
    r.data_count = frames_data_n;
    r.last = 1'b0;
    for (i = 0; i < sources; i++) begin
      if (hit_table[i] > flood_thr) begin
        r.kind = KIND_FLOOD;
        r.severity = (hit_table[i] > crit_thr) ? LVL_CRITICAL : LVL_WARNING;
        r.flood_mac = src_table[i];
        r.flood_count = hit_table[i];
        report_queue.push_back(r);
      end
    end
    // deauth share test without division
    share = frames_deauth_n;
    share = share * 100;
    bound = ratio_pct;
    bound = bound * frames_all;
    warn = share > bound;
    r.kind = KIND_SUMMARY;
    r.severity = LVL_INFO;
    r.flood_mac = '0;
    r.flood_count = '0;
    r.last = !warn;
    report_queue.push_back(r);
    if (warn) begin
      r.kind = KIND_RATIO;
      r.severity = LVL_WARNING;
      r.last = 1'b1;
      report_queue.push_back(r);
    end
    clear_session();
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    bit bad;
    if (rst) begin
      clear_session();
      flood_thr = FLOOD_THRESHOLD_RST;
      crit_thr = CRITICAL_THRESHOLD_RST;
      ratio_pct = RATIO_PERCENT_RST;
      report_queue.delete();
      mismatches = 0;
      results_seen = 0;
      floods_seen = 0;
      ratio_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {kind, severity, flood_mac, flood_count, total_count, deauth_count,
               data_count, last};
        results_seen++;
        if (got.kind == KIND_FLOOD) floods_seen++;
        if (got.kind == KIND_RATIO) ratio_seen++;
        if (report_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result kind %0d mac %h count %0d", $realtime,
                     got.kind, got.flood_mac, got.flood_count);
        end else begin
          want = report_queue.pop_front();
          bad = (got.kind !== want.kind) || (got.severity !== want.severity) ||
                (got.flood_mac !== want.flood_mac) ||
                (got.flood_count !== want.flood_count) ||
                (got.total_count !== want.total_count) ||
                (got.deauth_count !== want.deauth_count) ||
                (got.data_count !== want.data_count) || (got.last !== want.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected kind %0d sev %0d mac %h count %0d tot %0d deauth %0d data %0d last %0d",
                       want.kind, want.severity, want.flood_mac, want.flood_count,
                       want.total_count, want.deauth_count, want.data_count, want.last);
              $display("  actual   kind %0d sev %0d mac %h count %0d tot %0d deauth %0d data %0d last %0d",
                       got.kind, got.severity, got.flood_mac, got.flood_count,
                       got.total_count, got.deauth_count, got.data_count, got.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (mode == MODE_REPORT) predict_report();
        else tally_frame(frame_class, src_mac);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_FLOOD_THRESHOLD:    flood_thr = cfg_data;
          REG_CRITICAL_THRESHOLD: crit_thr = cfg_data;
          REG_RATIO_PERCENT:      ratio_pct = cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= report_queue.size();
  end

endmodule

/* sim/tb_deauth_flood_source_counter.sv */
// Top of the deauth flood source counter testbench: clock, reset, frame and
// register stimulus, receiver stalls and the verdict.
// Depends on dfsc_pkg, deauth_flood_source_counter and flood_report_checker.
module tb_deauth_flood_source_counter;
  timeunit 1ns;
  timeprecision 1ps;
  import dfsc_pkg::*;

  localparam int TABLE_DEPTH   = 32;
  localparam int RANDOM_ITEMS  = 420;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [1:0] CLASS_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE    = 2'd3;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             mode = MODE_FRAME;
  logic [1:0]       frame_class = CLASS_OTHER;
  logic [MAC_W-1:0] src_mac = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       kind;
  logic [1:0]       severity;
  logic [MAC_W-1:0] flood_mac;
  logic [CNT_W-1:0] flood_count;
  logic [CNT_W-1:0] total_count;
  logic [CNT_W-1:0] deauth_count;
  logic [CNT_W-1:0] data_count;
  logic             last;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = REG_FLOOD_THRESHOLD;
  logic [THR_W-1:0] cfg_data = '0;

  int mismatches, pending, results_seen, floods_seen, ratio_seen;
  int items_sent = 0;
  int burst_left = 0;
  int settings_used = 0;
  int cycle_count;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  deauth_flood_source_counter #(.TABLE_ENTRIES(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .frame_class(frame_class), .src_mac(src_mac),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .severity(severity), .flood_mac(flood_mac), .flood_count(flood_count),
    .total_count(total_count), .deauth_count(deauth_count), .data_count(data_count),
    .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  flood_report_checker #(.DEPTH(TABLE_DEPTH)) report_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .frame_class(frame_class), .src_mac(src_mac),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .severity(severity), .flood_mac(flood_mac), .flood_count(flood_count),
    .total_count(total_count), .deauth_count(deauth_count), .data_count(data_count),
    .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen),
    .floods_seen(floods_seen), .ratio_seen(ratio_seen)
  );

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MAC_W-1:0];
  endfunction

  // One input transfer. Valid stays high into the next item while the burst
  // lasts; at the end of a burst the sender goes quiet for a random gap.
  task automatic send(input logic m, input logic [1:0] cls, input logic [MAC_W-1:0] a);
    in_valid <= 1'b1;
    mode <= m;
    frame_class <= cls;
    src_mac <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // pending is a registered copy of the checker queue size, yet the first look already covers the last transfer
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [THR_W-1:0] ft, input logic [THR_W-1:0] ct,
                            input logic [THR_W-1:0] pct);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data <= THR_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_FLOOD_THRESHOLD;
    cfg_data <= ft;
    @(posedge clk);
    cfg_index <= REG_CRITICAL_THRESHOLD;
    cfg_data <= ct;
    @(posedge clk);
    cfg_index <= REG_RATIO_PERCENT;
    cfg_data <= pct;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // overflows the source table: 40 distinct sources, then repeats of old and dropped ones
  task automatic table_full_session();
    logic [MAC_W-1:0] base;
    int j;
    base = rand_mac();
    for (j = 0; j < 40; j++) send(MODE_FRAME, CLASS_DEAUTH, base ^ j);
    for (j = 0; j < 6; j++) send(MODE_FRAME, CLASS_DEAUTH, base ^ $urandom_range(0, 39));
    send(MODE_REPORT, 2'($urandom_range(0, 3)), rand_mac());
  endtask

  task automatic noise_session(input int n);
    int j;
    for (j = 0; j < n; j++)
      send(($urandom_range(0, 5) == 0) ? MODE_REPORT : MODE_FRAME,
           2'($urandom_range(0, 3)), rand_mac());
    send(MODE_REPORT, 2'($urandom_range(0, 3)), rand_mac());
  endtask

  // frames from a small pool of sources, some differing from another in one bit
  task automatic normal_session(input int n, input int n_macs);
    logic [MAC_W-1:0] pool [8];
    logic [MAC_W-1:0] a;
    int j, pick;
    pool[0] = rand_mac();
    for (j = 1; j < 8; j++)
      pool[j] = ($urandom_range(0, 1) == 0) ? rand_mac()
                : pool[0] ^ (48'd1 << $urandom_range(0, MAC_W - 1));
    for (j = 0; j < n; j++) begin
      pick = $urandom_range(0, 7);
      a = pool[$urandom_range(0, n_macs - 1)];
      if (pick < 4) send(MODE_FRAME, CLASS_DEAUTH, a);
      else if (pick < 6) send(MODE_FRAME, CLASS_DATA, rand_mac());
      else send(MODE_FRAME, (pick == 6) ? CLASS_OTHER : CLASS_UNUSED, a);
    end
    send(MODE_REPORT, 2'($urandom_range(0, 3)), rand_mac());
  endtask

  initial begin : receiver
    int style, seg, k;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        // long hold so the block backs up and stalls its input
        hold_done = 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end
      style = $urandom_range(0, 3);
      seg = $urandom_range(8, 60);
      for (k = 0; k < seg; k++) begin
        @(posedge clk);
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (k % 3 == 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int phase, phase_end, directed_items, pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: empty session, then unused class and ignored report fields
    send(MODE_REPORT, CLASS_UNUSED, MAC_ONES);
    send(MODE_FRAME, CLASS_OTHER, '0);
    send(MODE_FRAME, CLASS_UNUSED, MAC_ONES);
    send(MODE_FRAME, CLASS_DATA, rand_mac());
    send(MODE_FRAME, CLASS_DEAUTH, '0);
    send(MODE_REPORT, CLASS_DEAUTH, rand_mac());

    // warning and critical floods, near-duplicate source, ratio zero
    set_config(1, 2, 0);
    repeat (3) send(MODE_FRAME, CLASS_DEAUTH, MAC_ONES);
    repeat (2) send(MODE_FRAME, CLASS_DEAUTH, '0);
    send(MODE_FRAME, CLASS_DEAUTH, MAC_ONES ^ 48'd1);
    send(MODE_FRAME, CLASS_DATA, MAC_ONES);
    send(MODE_REPORT, CLASS_DATA, '0);

    // deauth share exactly at the ratio, then just above it
    set_config(0, 1, 50);
    send(MODE_FRAME, CLASS_DEAUTH, 48'h0000_0000_0001);
    send(MODE_FRAME, CLASS_DATA, 48'h0000_0000_0001);
    send(MODE_REPORT, CLASS_OTHER, MAC_ONES);
    send(MODE_FRAME, CLASS_DEAUTH, 48'h8000_0000_0000);
    send(MODE_FRAME, CLASS_DEAUTH, 48'h4000_0000_0000);
    send(MODE_FRAME, CLASS_OTHER, 48'h8000_0000_0000);
    send(MODE_REPORT, CLASS_UNUSED, '0);
    directed_items = items_sent;

    phase = 0;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      case (phase)
        0: set_config(0, 0, 0);
        1: set_config('1, '1, 100);
        2: set_config(3, 6, 50);
        3: set_config(2, 16'hFFFF, 16'hFFFF);  // ratio register keeps 127
        default: set_config(THR_W'($urandom_range(0, 6)), THR_W'($urandom_range(0, 12)),
                            THR_W'($urandom_range(0, 100)));
      endcase
      if (phase == 0) table_full_session();  // every source reported: longest report
      if (phase == 2) hold_req = 1'b1;
      phase_end = items_sent + $urandom_range(45, 70);
      while (items_sent < phase_end && items_sent - directed_items < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) table_full_session();
        else if (pick < 12) noise_session($urandom_range(2, 10));
        else normal_session($urandom_range(2, 25), $urandom_range(1, 8));
      end
      phase++;
    end

    wait_idle();
    $display("Covered %0d input transfers and %0d results over %0d register settings;",
             items_sent, results_seen, settings_used);
    $display("reports held %0d flood findings and %0d ratio warnings.", floods_seen,
             ratio_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
